// ===== rtl/etf_pkg.sv =====
// shared types, constants and fixed-point helpers for the escape-time iterator
`default_nettype none
package etf_pkg;

  localparam int unsigned MaxIterDefault = 256;
  localparam int DataW = 32;
  localparam int CountOutW = 9;
  localparam int CfgIdxW = 2;
  localparam int WideW = 40;

  localparam logic [CfgIdxW-1:0] REG_KIND = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_START_REAL = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_START_IMAG = 2'd2;

  // |z|^2 limit of 4.0 in Q16.48
  localparam logic [63:0] EscLimit = 64'h0004_0000_0000_0000;

  localparam logic signed [DataW-1:0] QMax = 32'sh7fff_ffff;
  localparam logic signed [DataW-1:0] QMin = 32'sh8000_0000;

  typedef logic signed [DataW-1:0] q_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [WideW-1:0] wide_t;

  typedef enum logic [1:0] {
    KIND_MANDEL = 2'd0,
    KIND_JULIA  = 2'd1,
    KIND_CUBIC  = 2'd2,
    KIND_MIXED  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CROSS,
    ST_SUM,
    ST_HOLD
  } state_t;

  typedef struct packed {
    prod_t p_rr;
    prod_t p_ii;
    prod_t p_ri;
  } sq_t;

  typedef struct packed {
    q_t    rr;
    q_t    ii;
    q_t    ri;
    prod_t p_iz;
    prod_t p_iir;
    prod_t p_rz;
    logic  esc;
  } cross_t;

  function automatic wide_t sx(input q_t a);
    return {{(WideW-DataW){a[DataW-1]}}, a};
  endfunction

  function automatic q_t sat_wide(input wide_t v);
    if (v[WideW-1:DataW-1] == {(WideW-DataW+1){v[WideW-1]}}) begin
      return v[DataW-1:0];
    end else if (v[WideW-1]) begin
      return QMin;
    end else begin
      return QMax;
    end
  endfunction

  // floor shift by the fraction width, then clamp
  function automatic q_t qmul_sat(input prod_t p);
    return sat_wide(p[63:24]);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/etf_square_cell.sv =====
// first cell of the iteration ring: exact products of the current z
`default_nettype none
module etf_square_cell
  import etf_pkg::*;
(
  input  wire logic clk,
  input  wire q_t   zr,
  input  wire q_t   zi,
  output sq_t       sq
);

  always_ff @(posedge clk) begin
    sq.p_rr <= prod_t'(zr) * prod_t'(zr);
    sq.p_ii <= prod_t'(zi) * prod_t'(zi);
    sq.p_ri <= prod_t'(zr) * prod_t'(zi);
  end

endmodule
`default_nettype wire

// ===== rtl/etf_cross_cell.sv =====
// second cell: clamped squares, cross products and escape test
`default_nettype none
module etf_cross_cell
  import etf_pkg::*;
(
  input  wire logic clk,
  input  wire sq_t  sq,
  input  wire q_t   zr,
  input  wire q_t   zi,
  output cross_t    cr_out
);

  q_t rr;
  q_t ii;
  logic [63:0] mag;

  assign rr = qmul_sat(sq.p_rr);
  assign ii = qmul_sat(sq.p_ii);
  assign mag = 64'(sq.p_rr[62:0]) + 64'(sq.p_ii[62:0]);

  always_ff @(posedge clk) begin
    cr_out.rr <= rr;
    cr_out.ii <= ii;
    cr_out.ri <= qmul_sat(sq.p_ri);
    cr_out.p_iz <= prod_t'(ii) * prod_t'(zi);
    cr_out.p_iir <= prod_t'(ii) * prod_t'(zr);
    cr_out.p_rz <= prod_t'(rr) * prod_t'(zi);
    cr_out.esc <= (mag > EscLimit);
  end

endmodule
`default_nettype wire

// ===== rtl/etf_update_cell.sv =====
// last cell: sums the terms of the chosen variant and holds z
`default_nettype none
module etf_update_cell
  import etf_pkg::*;
(
  input  wire logic   clk,
  input  wire cross_t cr_in,
  input  wire kind_t  kind,
  input  wire q_t     cr,
  input  wire q_t     ci,
  input  wire logic   load,
  input  wire q_t     load_real,
  input  wire q_t     load_imag,
  input  wire logic   step,
  output q_t          zr,
  output q_t          zi
);

  q_t iz;
  q_t iir3;
  q_t rz3;
  q_t ri2;
  q_t zr_next;
  q_t zi_next;

  always_comb begin
    iz = qmul_sat(cr_in.p_iz);
    iir3 = sat_wide(sx(qmul_sat(cr_in.p_iir)) + (sx(qmul_sat(cr_in.p_iir)) <<< 1));
    rz3 = sat_wide(sx(qmul_sat(cr_in.p_rz)) + (sx(qmul_sat(cr_in.p_rz)) <<< 1));
    ri2 = sat_wide(sx(cr_in.ri) <<< 1);
    unique case (kind)
      KIND_MANDEL, KIND_JULIA: begin
        zr_next = sat_wide(sx(cr_in.rr) - sx(cr_in.ii) + sx(cr));
        zi_next = sat_wide(sx(ri2) + sx(ci));
      end
      KIND_CUBIC: begin
        zr_next = sat_wide(sx(cr_in.rr) - sx(iz) + sx(cr));
        zi_next = sat_wide(sx(ri2) + sx(ci));
      end
      KIND_MIXED: begin
        zr_next = sat_wide(sx(cr_in.rr) - sx(iir3) + sx(cr));
        zi_next = sat_wide(sx(rz3) + sx(cr_in.ii) + sx(ci));
      end
      default: begin
        zr_next = cr_in.rr;
        zi_next = cr_in.ii;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    priority if (load) begin
      zr <= load_real;
      zi <= load_imag;
    end else if (step) begin
      zr <= zr_next;
      zi <= zi_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/escape_time_fractal_iterator_unit.sv =====
// escape-time fractal iterator: three-cell ring of multiply and sum stages
// one complex step passes through the square, cross and update cells in turn
// points are iterated one at a time
// a new point is taken while the previous result word waits in the output register
// synchronous reset clears the handshake state and the configuration registers
`default_nettype none
module escape_time_fractal_iterator_unit
  import etf_pkg::*;
#(
  parameter int unsigned MAX_ITER = MaxIterDefault
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CfgIdxW-1:0]   cfg_index,
  input  wire logic [DataW-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic signed [DataW-1:0] point_real,
  input  wire logic signed [DataW-1:0] point_imag,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [CountOutW-1:0]      iteration_count
);

  localparam int CountW = $clog2(MAX_ITER + 1);

  kind_t fractal_kind;
  q_t start_real;
  q_t start_imag;
  q_t cr;
  q_t ci;
  q_t zr;
  q_t zi;
  logic [CountW-1:0] n;
  logic [CountW+CountOutW-1:0] n_wide;
  state_t state;
  state_t state_next;
  logic accept;
  logic finish;
  logic step;
  logic out_load;
  sq_t sq;
  cross_t cross_terms;

  assign cfg_ready = 1'b1;
  assign accept = in_valid && !in_stall;
  assign finish = cross_terms.esc || (n == CountW'(MAX_ITER));
  assign n_wide = {{CountOutW{1'b0}}, n};

  always_ff @(posedge clk) begin
    if (rst) begin
      fractal_kind <= KIND_MANDEL;
      start_real <= '0;
      start_imag <= '0;
    end else if (cfg_valid && cfg_ready) begin
      priority case (cfg_index)
        REG_KIND:       fractal_kind <= kind_t'(cfg_data[1:0]);
        REG_START_REAL: start_real <= cfg_data;
        REG_START_IMAG: start_imag <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall = 1'b1;
    step = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_CROSS;
      ST_CROSS: state_next = ST_SUM;
      ST_SUM: begin
        if (!finish) begin
          step = 1'b1;
          state_next = ST_MUL;
        end else if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cr <= point_real;
      ci <= point_imag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else if (accept) begin
      n <= '0;
    end else if (step) begin
      n <= n + CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      iteration_count <= n_wide[CountOutW-1:0];
    end
  end

  etf_square_cell u_square (
    .clk (clk),
    .zr  (zr),
    .zi  (zi),
    .sq  (sq)
  );

  etf_cross_cell u_cross (
    .clk    (clk),
    .sq     (sq),
    .zr     (zr),
    .zi     (zi),
    .cr_out (cross_terms)
  );

  etf_update_cell u_update (
    .clk       (clk),
    .cr_in     (cross_terms),
    .kind      (fractal_kind),
    .cr        (cr),
    .ci        (ci),
    .load      (accept),
    .load_real ((fractal_kind == KIND_MANDEL) ? '0 : start_real),
    .load_imag ((fractal_kind == KIND_MANDEL) ? '0 : start_imag),
    .step      (step),
    .zr        (zr),
    .zi        (zi)
  );

endmodule
`default_nettype wire
